FILE: src/fobs_pkg.sv
// Shared constants and the arctangent table for the flux observer.
package fobs_pkg;

  localparam int unsigned GainWidth  = 16;
  localparam int unsigned LimitWidth = 31;
  localparam int unsigned MaxSteps   = 24;
  localparam int unsigned IdxWidth   = 2;
  localparam int unsigned CfgWidth   = 31;

  localparam logic [IdxWidth-1:0] RegDtGain    = 2'd0;
  localparam logic [IdxWidth-1:0] RegRsDtGain  = 2'd1;
  localparam logic [IdxWidth-1:0] RegLsGain    = 2'd2;
  localparam logic [IdxWidth-1:0] RegFluxLimit = 2'd3;

  localparam logic [30:0] GainKQ30 = 31'd1768195364;
  localparam logic [31:0] InvKQ32  = 32'd2608131495;

  // Arctangent of 2^-i as a fraction of one turn in 32 bits.
  function automatic logic [31:0] turn_atan(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/fobs_if.sv
// Valid/ready channel interfaces for samples and flux results.
interface fobs_in_if #(parameter int unsigned SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] i_alpha;
  logic signed [SAMPLE_WIDTH-1:0] i_beta;
  logic signed [SAMPLE_WIDTH-1:0] v_alpha;
  logic signed [SAMPLE_WIDTH-1:0] v_beta;
  modport source (output valid, i_alpha, i_beta, v_alpha, v_beta, input ready);
  modport sink (input valid, i_alpha, i_beta, v_alpha, v_beta, output ready);
endinterface

interface fobs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_alpha;
  logic signed [31:0] flux_beta;
  logic signed [15:0] rotor_angle;
  logic               was_clamped;
  modport source (output valid, flux_alpha, flux_beta, rotor_angle, was_clamped,
                  input ready);
  modport sink (input valid, flux_alpha, flux_beta, rotor_angle, was_clamped,
                output ready);
endinterface

FILE: src/fobs_alu.sv
// Shared datapath unit: one multiply-accumulate or one CORDIC micro-rotation per cycle.
module fobs_alu #(
  parameter int unsigned W  = 40,
  parameter int unsigned MW = 17
) (
  input  logic                 mac_i,
  input  logic signed [MW-1:0] ma_i,
  input  logic        [15:0]   mb_i,
  input  logic                 sub_i,
  input  logic signed [W-1:0]  acc_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic        [4:0]    sh_i,
  input  logic                 up_i,
  output logic signed [W-1:0]  acc_o,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o
);
  logic signed [MW+16:0] prod;
  logic signed [W-1:0]   prod_x;
  logic signed [W-1:0]   xs;
  logic signed [W-1:0]   ys;

  always_comb begin
    prod   = ma_i * $signed({1'b0, mb_i});
    prod_x = W'(prod);
    acc_o  = sub_i ? acc_i - prod_x : acc_i + prod_x;
    xs     = x_i >>> sh_i;
    ys     = y_i >>> sh_i;
    // Up means a rotation that drives y toward zero from above.
    if (mac_i) begin
      x_o = x_i;
      y_o = y_i;
    end else if (up_i) begin
      x_o = x_i + ys;
      y_o = y_i - xs;
    end else begin
      x_o = x_i - ys;
      y_o = y_i + xs;
    end
  end
endmodule

FILE: src/flux_observer_clamped.sv
// Flux observer with circular magnitude clamp, top level.
// Usage: one sample transfer on in_if (i_alpha, i_beta, v_alpha, v_beta)
// yields exactly one result transfer on out_if (clamped flux, angle, flag).
// The user must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle (unenforced); indexes: 0 dt_gain, 1 rs_dt_gain, 2 ls_gain, 3 flux_limit.
// One item is processed at a time through a single shared multiply-accumulate
// and shift-add unit under a sequencer, in these steps:
//   multiply-accumulate, three products per axis (StMac),
//   saturation and half-plane fold (StFold),
//   CORDIC vectoring over CORDIC_STEPS micro-rotations, at most MaxSteps (StVec),
//   forming the limit products and comparing against them (StLim),
//   replay of the rotations when the vector is clamped (StRot),
//   loading the result register (StDone).
// A zero flux vector skips the vectoring, the limit products and the rotations.
// in_if.ready stays low until the result has been transferred, so the block
// takes no new sample until the previous result has left out_if.
// Reset clears flux, previous currents, configuration and the counter to zero.
// A stalled receiver holds the result and keeps in_if.ready low.
module flux_observer_clamped #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FLUX_WIDTH   = 32,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fobs_pkg::IdxWidth-1:0] cfg_idx_i,
  input  logic [fobs_pkg::CfgWidth-1:0] cfg_data_i,
  fobs_in_if.sink                       in_if,
  fobs_out_if.source                    out_if
);
  import fobs_pkg::*;

  localparam int unsigned MW = SAMPLE_WIDTH + 1;
  localparam int unsigned WSum = SAMPLE_WIDTH + 19;
  localparam int unsigned WFlux = (FLUX_WIDTH + 8 > 40) ? FLUX_WIDTH + 8 : 40;
  localparam int unsigned W = (WSum > WFlux) ? WSum : WFlux;
  localparam int Shift = int'(SAMPLE_WIDTH) + 15 - (int'(FLUX_WIDTH) - 8);
  localparam int unsigned Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam logic signed [W-1:0] FluxMax = W'((64'sd1 <<< (FLUX_WIDTH - 1)) - 1);
  localparam logic signed [W-1:0] FluxMin = -FluxMax - W'(1);

  typedef enum logic [2:0] {
    StIdle, StMac, StFold, StVec, StLim, StRot, StDone, StOut
  } state_e;

  state_e state_q;
  logic [15:0] dt_q, rs_q, ls_q;
  logic [LimitWidth-1:0] lim_q;
  logic signed [FLUX_WIDTH-1:0] fa_q, fb_q;
  logic signed [SAMPLE_WIDTH-1:0] pa_q, pb_q, ia_q, ib_q, va_q, vb_q;
  logic signed [W-1:0] acc_q, da_q, x_q, y_q;
  logic [4:0] cnt_q;
  logic [31:0] ang_q;
  logic [MaxSteps-1:0] dirs_q;
  logic flip_q, clamp_q;
  logic [63:0] limk_q;

  logic signed [MW-1:0] ma;
  logic [15:0] mb;
  logic sub;
  logic up;
  logic signed [W-1:0] acc_n, x_n, y_n;

  fobs_alu #(.W(W), .MW(MW)) u_alu (
    .mac_i(state_q == StMac), .ma_i(ma), .mb_i(mb), .sub_i(sub),
    .acc_i(acc_q), .x_i(x_q), .y_i(y_q), .sh_i(cnt_q), .up_i(up),
    .acc_o(acc_n), .x_o(x_n), .y_o(y_n)
  );

  // Operand selection; samples are widened by one bit so the current change fits.
  always_comb begin
    logic signed [MW-1:0] i_s, p_s, v_s;
    i_s = MW'(cnt_q[2] ? ib_q : ia_q);
    p_s = MW'(cnt_q[2] ? pb_q : pa_q);
    v_s = MW'(cnt_q[2] ? vb_q : va_q);
    ma = v_s;
    mb = dt_q;
    sub = 1'b0;
    case (cnt_q[1:0])
      2'd1: begin ma = i_s; mb = rs_q; sub = 1'b1; end
      2'd2: begin ma = i_s - p_s; mb = ls_q; sub = 1'b1; end
      default: ;
    endcase
    up = (state_q == StRot) ? !dirs_q[cnt_q] : (y_q > 0);
  end

  function automatic logic signed [W-1:0] to_flux(input logic signed [W-1:0] p);
    if (Shift > 0) return p >>> Shift;
    else return p <<< (-Shift);
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [W-1:0] v);
    if (v > FluxMax) return FluxMax;
    if (v < FluxMin) return FluxMin;
    return v;
  endfunction

  logic signed [W-1:0] nfa, nfb;
  always_comb begin
    nfa = sat(W'(fa_q) + to_flux(da_q));
    nfb = sat(W'(fb_q) + to_flux(acc_q));
  end

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dt_q <= '0; rs_q <= '0; ls_q <= '0; lim_q <= '0;
      fa_q <= '0; fb_q <= '0; pa_q <= '0; pb_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDtGain:    dt_q  <= cfg_data_i[15:0];
          RegRsDtGain:  rs_q  <= cfg_data_i[15:0];
          RegLsGain:    ls_q  <= cfg_data_i[15:0];
          RegFluxLimit: lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_if.valid) begin
            ia_q <= in_if.i_alpha; ib_q <= in_if.i_beta;
            va_q <= in_if.v_alpha; vb_q <= in_if.v_beta;
            acc_q <= '0; cnt_q <= '0;
            state_q <= StMac;
          end
        end
        StMac: begin
          // Counter codes 0..2 build the alpha sum, 4..6 the beta sum.
          if (cnt_q == 5'd2) begin
            da_q <= acc_n; acc_q <= '0; cnt_q <= 5'd4;
          end else if (cnt_q == 5'd6) begin
            acc_q <= acc_n; state_q <= StFold;
          end else begin
            acc_q <= acc_n; cnt_q <= cnt_q + 5'd1;
          end
        end
        StFold: begin
          fa_q <= FLUX_WIDTH'(nfa); fb_q <= FLUX_WIDTH'(nfb);
          pa_q <= ia_q; pb_q <= ib_q;
          clamp_q <= 1'b0; dirs_q <= '0; cnt_q <= '0;
          if (nfa < 0) begin
            x_q <= -nfa; y_q <= -nfb; flip_q <= 1'b1; ang_q <= 32'h8000_0000;
          end else begin
            x_q <= nfa; y_q <= nfb; flip_q <= 1'b0; ang_q <= '0;
          end
          if (nfa == 0 && nfb == 0) state_q <= StDone;
          else if (Steps == 0) state_q <= StLim;
          else state_q <= StVec;
        end
        StVec: begin
          x_q <= x_n; y_q <= y_n;
          ang_q <= up ? ang_q + turn_atan(cnt_q) : ang_q - turn_atan(cnt_q);
          dirs_q[cnt_q] <= up;
          if (cnt_q == 5'(Steps - 1)) begin
            cnt_q <= '0; state_q <= StLim;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StLim: begin
          // First cycle forms lim*K, second compares it and forms lim/K.
          if (cnt_q == 5'd0) begin
            limk_q <= (64'(lim_q) * 64'(GainKQ30)) >> 30;
            cnt_q <= 5'd1;
          end else if (x_q > $signed({1'b0, limk_q[W-2:0]}) || limk_q[63:W-1] != '0 ?
                       (limk_q[63:W-1] == '0) : 1'b0) begin
            x_q <= W'((64'(lim_q) * 64'(InvKQ32)) >> 32);
            y_q <= '0; cnt_q <= '0; clamp_q <= 1'b1;
            state_q <= (Steps == 0) ? StDone : StRot;
          end else begin
            state_q <= StDone;
          end
        end
        StRot: begin
          x_q <= x_n; y_q <= y_n;
          if (cnt_q == 5'(Steps - 1)) state_q <= StDone;
          else cnt_q <= cnt_q + 5'd1;
        end
        StDone: begin
          if (clamp_q) begin
            fa_q <= FLUX_WIDTH'(sat(flip_q ? -x_q : x_q));
            fb_q <= FLUX_WIDTH'(sat(flip_q ? -y_q : y_q));
          end
          state_q <= StOut;
        end
        StOut: begin
          if (out_if.ready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.flux_alpha  = 32'(fa_q);
  assign out_if.flux_beta   = 32'(fb_q);
  assign out_if.rotor_angle = 16'((ang_q + 32'h8000) >> 16);
  assign out_if.was_clamped = clamp_q;
endmodule

FILE: src/fobs_checker.sv
// Port-level checker for the flux observer, bound to the top level.
module fobs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic was_clamped,
  input logic [31:0] flux_alpha
);
  // One item at a time: never ready while a result is pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // A result follows a transfer, not immediately.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // After a result transfer the block takes input again.
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready) |=> in_ready) else $error("not ready after result");
  // A held result keeps its flag and its alpha flux.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> $stable(was_clamped) && $stable(flux_alpha))
    else $error("result changed while stalled");
endmodule

bind flux_observer_clamped fobs_checker u_fobs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .was_clamped(out_if.was_clamped), .flux_alpha(out_if.flux_alpha)
);
